FILE: rtl/core/sha_pkg.sv
// Shared types, constants and round functions of the SHA-256 byte stream hasher.
package sha_pkg;

   localparam int Q_DEPTH = 4;
   localparam int Q_AW    = $clog2(Q_DEPTH);
   localparam int Q_CW    = $clog2(Q_DEPTH + 1);

   localparam logic       MODE_ABSORB = 1'b0;
   localparam logic       MODE_FINISH = 1'b1;
   localparam logic [7:0] PAD_BYTE    = 8'h80;
   localparam logic [2:0] LAST_IDX    = 3'd7;
   localparam logic [3:0] LAST_WORD   = 4'd15;
   localparam logic [3:0] LEN_WORD    = 4'd14;
   localparam logic [5:0] LAST_ROUND  = 6'd63;
   localparam logic [63:0] BLOCK_BITS = 64'd512;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_PAD,
      ST_LENLO,
      ST_ROUND,
      ST_FOLD,
      ST_EMIT
   } back_state_type;

   // One queue entry: a full message word, or on finish the word that carries
   // the 0x80 marker together with the count of message bytes in it.
   typedef struct packed {
      logic        fin;
      logic [31:0] word;
      logic [1:0]  nbytes;
   } q_entry_type;

   typedef struct packed {
      logic        push;
      q_entry_type entry;
   } q_push_type;

   typedef struct packed {
      logic        valid;
      q_entry_type entry;
   } q_head_type;

   function automatic logic [31:0] init_hash(input logic [2:0] idx);
      logic [31:0] r;
      case (idx)
         3'd0: r = 32'h6a09e667;
         3'd1: r = 32'hbb67ae85;
         3'd2: r = 32'h3c6ef372;
         3'd3: r = 32'ha54ff53a;
         3'd4: r = 32'h510e527f;
         3'd5: r = 32'h9b05688c;
         3'd6: r = 32'h1f83d9ab;
         3'd7: r = 32'h5be0cd19;
         default: r = 32'h0;
      endcase
      return r;
   endfunction

   function automatic logic [31:0] round_k(input logic [5:0] idx);
      logic [31:0] r;
      case (idx)
         6'd0:  r = 32'h428a2f98;  6'd1:  r = 32'h71374491;
         6'd2:  r = 32'hb5c0fbcf;  6'd3:  r = 32'he9b5dba5;
         6'd4:  r = 32'h3956c25b;  6'd5:  r = 32'h59f111f1;
         6'd6:  r = 32'h923f82a4;  6'd7:  r = 32'hab1c5ed5;
         6'd8:  r = 32'hd807aa98;  6'd9:  r = 32'h12835b01;
         6'd10: r = 32'h243185be;  6'd11: r = 32'h550c7dc3;
         6'd12: r = 32'h72be5d74;  6'd13: r = 32'h80deb1fe;
         6'd14: r = 32'h9bdc06a7;  6'd15: r = 32'hc19bf174;
         6'd16: r = 32'he49b69c1;  6'd17: r = 32'hefbe4786;
         6'd18: r = 32'h0fc19dc6;  6'd19: r = 32'h240ca1cc;
         6'd20: r = 32'h2de92c6f;  6'd21: r = 32'h4a7484aa;
         6'd22: r = 32'h5cb0a9dc;  6'd23: r = 32'h76f988da;
         6'd24: r = 32'h983e5152;  6'd25: r = 32'ha831c66d;
         6'd26: r = 32'hb00327c8;  6'd27: r = 32'hbf597fc7;
         6'd28: r = 32'hc6e00bf3;  6'd29: r = 32'hd5a79147;
         6'd30: r = 32'h06ca6351;  6'd31: r = 32'h14292967;
         6'd32: r = 32'h27b70a85;  6'd33: r = 32'h2e1b2138;
         6'd34: r = 32'h4d2c6dfc;  6'd35: r = 32'h53380d13;
         6'd36: r = 32'h650a7354;  6'd37: r = 32'h766a0abb;
         6'd38: r = 32'h81c2c92e;  6'd39: r = 32'h92722c85;
         6'd40: r = 32'ha2bfe8a1;  6'd41: r = 32'ha81a664b;
         6'd42: r = 32'hc24b8b70;  6'd43: r = 32'hc76c51a3;
         6'd44: r = 32'hd192e819;  6'd45: r = 32'hd6990624;
         6'd46: r = 32'hf40e3585;  6'd47: r = 32'h106aa070;
         6'd48: r = 32'h19a4c116;  6'd49: r = 32'h1e376c08;
         6'd50: r = 32'h2748774c;  6'd51: r = 32'h34b0bcb5;
         6'd52: r = 32'h391c0cb3;  6'd53: r = 32'h4ed8aa4a;
         6'd54: r = 32'h5b9cca4f;  6'd55: r = 32'h682e6ff3;
         6'd56: r = 32'h748f82ee;  6'd57: r = 32'h78a5636f;
         6'd58: r = 32'h84c87814;  6'd59: r = 32'h8cc70208;
         6'd60: r = 32'h90befffa;  6'd61: r = 32'ha4506ceb;
         6'd62: r = 32'hbef9a3f7;  6'd63: r = 32'hc67178f2;
         default: r = 32'h0;
      endcase
      return r;
   endfunction

   function automatic logic [31:0] big_sig0(input logic [31:0] x);
      return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
   endfunction

   function automatic logic [31:0] big_sig1(input logic [31:0] x);
      return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
   endfunction

   function automatic logic [31:0] small_sig0(input logic [31:0] x);
      return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
   endfunction

   function automatic logic [31:0] small_sig1(input logic [31:0] x);
      return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
   endfunction

endpackage

FILE: rtl/core/sha_req_if.sv
// Request channel interface: mode and message byte with valid/ready.
interface sha_req_if;
   logic       valid;
   logic       ready;
   logic       mode;
   logic [7:0] data_byte;

   modport source (output valid, output mode, output data_byte, input ready);
   modport sink (input valid, input mode, input data_byte, output ready);
endinterface

FILE: rtl/core/sha_rsp_if.sv
// Response channel interface: one digest word with its index and last flag.
interface sha_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_index;
   logic        last_word;

   modport source (output valid, output digest_word, output word_index, output last_word,
                   input ready);
   modport sink (input valid, input digest_word, input word_index, input last_word,
                 output ready);
endinterface

FILE: rtl/core/sha256_byte_stream_hasher_top.sv
// SHA-256 hasher over a byte stream, built from front end, word queue and back end.
//
// Usage: the req_ch channel takes one byte per handshake: mode 0 adds data_byte to
// the current message, mode 1 ends it. After an end, rsp_ch delivers eight
// digest words, word_index 0 (most significant) first, last_word high on the
// eighth; the hasher then starts a new message from the initial hash values.
// Throughput: the front end packs four bytes into a queue word, one byte per
// cycle while the queue has room. The back end loads one queue word per cycle
// while the queue holds one, then runs the 64 rounds and the fold on the block.
// The four-entry queue takes only 16 bytes while a block is compressed, before
// req_ch stalls, so a steady byte stream is held up during each block.
// The first digest word follows the end word once the back end has padded and
// compressed the last block, or two blocks when the length needs an extra one.
// While rsp_ch is stalled the digest words hold and the front end keeps
// accepting bytes until the queue fills. Synchronous reset clears the queue,
// the byte count and the bit counter and loads the initial hash values.
module sha256_byte_stream_hasher_top (
   input  logic      clock,
   input  logic      reset,
   sha_req_if.sink   req_ch,
   sha_rsp_if.source rsp_ch
);
   import sha_pkg::*;

   q_push_type q_push;
   q_head_type q_head;
   logic       q_full;
   logic       q_pop;

   sha_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req    (req_ch),
      .q_full (q_full),
      .q_push (q_push)
   );

   sha_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .q_push (q_push),
      .pop    (q_pop),
      .full   (q_full),
      .head   (q_head)
   );

   sha_back u_back (
      .clock (clock),
      .reset (reset),
      .head  (q_head),
      .pop   (q_pop),
      .rsp   (rsp_ch)
   );

`ifndef SYNTH
   a_pop_needs_entry: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_head.valid)
      else $error("back end popped an empty queue");

   a_push_needs_room: assert property (@(posedge clock) disable iff (reset)
      q_push.push |-> !q_full)
      else $error("front end pushed into a full queue");

   a_word_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.ready && !rsp_ch.last_word) |=>
      (rsp_ch.valid && rsp_ch.word_index == $past(rsp_ch.word_index) + 3'd1))
      else $error("digest words out of order");

   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (rsp_ch.last_word == (rsp_ch.word_index == LAST_IDX)))
      else $error("last word flag does not match word index");
`endif

endmodule

FILE: rtl/core/sha_front.sv
// Front end: packs accepted bytes into big-endian words and queues them.
module sha_front (
   input  logic                clock,
   input  logic                reset,
   sha_req_if.sink             req,
   input  logic                q_full,
   output sha_pkg::q_push_type q_push
);
   import sha_pkg::*;

   logic [1:0]  cnt_ff, cnt_in;
   logic [31:0] acc_ff, acc_in;
   logic [31:0] pad_word;
   logic        accept;

   assign req.ready = !q_full;
   assign accept    = req.valid && req.ready;

   always_comb begin
      acc_in   = acc_ff;
      pad_word = '0;
      for (int j = 0; j < 4; j++) begin
         if (2'(j) == cnt_ff) begin
            acc_in[31 - 8 * j -: 8]   = req.data_byte;
            pad_word[31 - 8 * j -: 8] = PAD_BYTE;
         end else if (2'(j) < cnt_ff) begin
            pad_word[31 - 8 * j -: 8] = acc_ff[31 - 8 * j -: 8];
         end
      end
   end

   always_comb begin
      cnt_in             = cnt_ff;
      q_push.push        = 1'b0;
      q_push.entry.fin   = 1'b0;
      q_push.entry.word  = acc_in;
      q_push.entry.nbytes = cnt_ff;
      if (accept) begin
         if (req.mode == MODE_FINISH) begin
            q_push.push       = 1'b1;
            q_push.entry.fin  = 1'b1;
            q_push.entry.word = pad_word;
            cnt_in            = '0;
         end else begin
            cnt_in      = cnt_ff + 2'd1;
            q_push.push = (cnt_ff == 2'd3);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req.mode == MODE_ABSORB) begin
         acc_ff <= acc_in;
      end
   end

endmodule

FILE: rtl/core/sha_queue.sv
// Short word queue between the byte front end and the compression back end.
module sha_queue (
   input  logic                clock,
   input  logic                reset,
   input  sha_pkg::q_push_type q_push,
   input  logic                pop,
   output logic                full,
   output sha_pkg::q_head_type head
);
   import sha_pkg::*;

   q_entry_type      q_ff [Q_DEPTH];
   logic [Q_AW-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [Q_CW-1:0]  count_ff, count_in;

   assign full       = (count_ff == Q_CW'(Q_DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.entry = q_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (q_push.push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !q_push.push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (q_push.push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_push.push) begin
         q_ff[wr_ptr_ff] <= q_push.entry;
      end
   end

endmodule

FILE: rtl/core/sha_back.sv
// Back end: block loading, padding, 64-round compression and digest output.
module sha_back (
   input  logic                clock,
   input  logic                reset,
   input  sha_pkg::q_head_type head,
   output logic                pop,
   sha_rsp_if.source           rsp
);
   import sha_pkg::*;

   back_state_type state_ff, state_in;
   logic [31:0] w_ff [16];
   logic [31:0] chain_ff [8];
   logic [31:0] v_ff [8];
   logic [31:0] fold [8];
   logic [3:0]  wc_ff;
   logic [5:0]  rnd_ff;
   logic [2:0]  idx_ff;
   logic        fin_ff;
   logic        len_done_ff;
   logic [63:0] msg_bits_ff;
   logic [63:0] len_ff;
   logic [31:0] t1, t2, w_next;
   logic        shift_en;
   logic [31:0] shift_word;
   logic        rsp_take;
   logic        last_take;

   // Round datapath and message schedule over the sliding 16-word window.
   always_comb begin
      t1 = v_ff[7] + big_sig1(v_ff[4]) + ((v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]))
           + round_k(rnd_ff) + w_ff[0];
      t2 = big_sig0(v_ff[0]) + ((v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]));
      w_next = small_sig1(w_ff[14]) + w_ff[9] + small_sig0(w_ff[1]) + w_ff[0];
      for (int i = 0; i < 8; i++) begin
         fold[i] = chain_ff[i] + v_ff[i];
      end
   end

   always_comb begin
      shift_en   = 1'b0;
      shift_word = head.entry.word;
      case (state_ff)
         ST_LOAD: begin
            shift_en = head.valid;
         end
         ST_PAD: begin
            shift_en   = 1'b1;
            shift_word = (wc_ff == LEN_WORD) ? len_ff[63:32] : '0;
         end
         ST_LENLO: begin
            shift_en   = 1'b1;
            shift_word = len_ff[31:0];
         end
         ST_ROUND: begin
            shift_en   = 1'b1;
            shift_word = w_next;
         end
         default: begin
            shift_en = 1'b0;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD: begin
            if (head.valid) begin
               if (wc_ff == LAST_WORD) begin
                  state_in = ST_ROUND;
               end else if (head.entry.fin) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            if (wc_ff == LEN_WORD) begin
               state_in = ST_LENLO;
            end else if (wc_ff == LAST_WORD) begin
               state_in = ST_ROUND;
            end
         end
         ST_LENLO: begin
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            if (rnd_ff == LAST_ROUND) begin
               state_in = ST_FOLD;
            end
         end
         ST_FOLD: begin
            if (len_done_ff) begin
               state_in = ST_EMIT;
            end else if (fin_ff) begin
               state_in = ST_PAD;
            end else begin
               state_in = ST_LOAD;
            end
         end
         ST_EMIT: begin
            if (last_take) begin
               state_in = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_comb begin
      pop             = (state_ff == ST_LOAD) && head.valid;
      rsp.valid       = (state_ff == ST_EMIT);
      rsp.digest_word = chain_ff[idx_ff];
      rsp.word_index  = idx_ff;
      rsp.last_word   = (idx_ff == LAST_IDX);
      rsp_take        = rsp.valid && rsp.ready;
      last_take       = rsp_take && (idx_ff == LAST_IDX);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_LOAD;
         wc_ff       <= '0;
         rnd_ff      <= '0;
         idx_ff      <= '0;
         fin_ff      <= 1'b0;
         len_done_ff <= 1'b0;
         msg_bits_ff <= '0;
         for (int i = 0; i < 8; i++) begin
            chain_ff[i] <= init_hash(3'(i));
            v_ff[i]     <= init_hash(3'(i));
         end
      end else begin
         state_ff <= state_in;
         if (shift_en && state_ff != ST_ROUND) begin
            wc_ff <= wc_ff + 4'd1;
         end
         if (pop && head.entry.fin) begin
            fin_ff <= 1'b1;
         end
         if (state_ff == ST_LENLO) begin
            len_done_ff <= 1'b1;
         end
         if (state_ff == ST_ROUND) begin
            rnd_ff  <= rnd_ff + 6'd1;
            v_ff[7] <= v_ff[6];
            v_ff[6] <= v_ff[5];
            v_ff[5] <= v_ff[4];
            v_ff[4] <= v_ff[3] + t1;
            v_ff[3] <= v_ff[2];
            v_ff[2] <= v_ff[1];
            v_ff[1] <= v_ff[0];
            v_ff[0] <= t1 + t2;
         end
         if (state_ff == ST_FOLD) begin
            msg_bits_ff <= msg_bits_ff + BLOCK_BITS;
            for (int i = 0; i < 8; i++) begin
               chain_ff[i] <= fold[i];
               v_ff[i]     <= fold[i];
            end
         end
         if (rsp_take) begin
            idx_ff <= idx_ff + 3'd1;
         end
         // Taking the last digest word returns the hasher to its initial state.
         if (last_take) begin
            fin_ff      <= 1'b0;
            len_done_ff <= 1'b0;
            msg_bits_ff <= '0;
            for (int i = 0; i < 8; i++) begin
               chain_ff[i] <= init_hash(3'(i));
               v_ff[i]     <= init_hash(3'(i));
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (shift_en) begin
         for (int i = 0; i < 15; i++) begin
            w_ff[i] <= w_ff[i + 1];
         end
         w_ff[15] <= shift_word;
      end
      // Total length in bits: earlier blocks plus whole words in this block plus bytes of the last word.
      if (pop && head.entry.fin) begin
         len_ff <= msg_bits_ff + {55'd0, wc_ff, head.entry.nbytes, 3'b000};
      end
   end

endmodule
